### hdl/plcr_pkg.sv
// Shared types, widths and codes for the point-to-line classify and reflect unit.
// No dependencies; every other file in this folder imports it.
package plcr_pkg;

    localparam int COORD_BITS = 12;
    localparam int FRAC_BITS  = 8;
    localparam int RES_W      = COORD_BITS + FRAC_BITS + 3;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int V_W        = 2 * COORD_BITS + 3;
    localparam int D_W        = 2 * COORD_BITS + 2;
    localparam int MAG_W      = 3 * COORD_BITS + FRAC_BITS + 3;
    localparam int NUM_W      = MAG_W + 1;
    localparam int Q_W        = COORD_BITS + FRAC_BITS + 4;
    localparam int R_W        = D_W + 1;
    localparam int QDEPTH     = 4;
    localparam int QA_W       = $clog2(QDEPTH);

    localparam logic [Q_W:0] MAXPOS = (Q_W + 1)'((64'd1 << (RES_W - 1)) - 64'd1);

    typedef enum logic [1:0] {
        SIDE_ON    = 2'd0,
        SIDE_LEFT  = 2'd1,
        SIDE_RIGHT = 2'd2
    } t_side;

    typedef enum logic [1:0] {
        CFG_END_A_X = 2'd0,
        CFG_END_A_Y = 2'd1,
        CFG_END_B_X = 2'd2,
        CFG_END_B_Y = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic signed [DIFF_W-1:0]     a;
        logic signed [DIFF_W-1:0]     b;
        logic signed [COORD_BITS-1:0] x1;
        logic signed [COORD_BITS-1:0] y1;
        logic signed [COORD_BITS-1:0] lox;
        logic signed [COORD_BITS-1:0] hix;
        logic signed [COORD_BITS-1:0] loy;
        logic signed [COORD_BITS-1:0] hiy;
        logic [D_W-1:0]               d;
    } t_line;

    typedef struct packed {
        logic signed [NUM_W-1:0] num_x;
        logic signed [NUM_W-1:0] num_y;
        t_side                   side;
        logic                    on_seg;
        logic                    degen;
    } t_job;

endpackage

### hdl/plcr_front.sv
// Front pipeline: accepts points, evaluates the line value, classifies the point
// and forms the exact reflection numerators. Depends on plcr_pkg.
module plcr_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic signed [plcr_pkg::COORD_BITS-1:0] i_pt_x,
    input  logic signed [plcr_pkg::COORD_BITS-1:0] i_pt_y,
    input  plcr_pkg::t_line                 i_line,
    output logic                            o_job_valid,
    output plcr_pkg::t_job                  o_job,
    input  logic                            i_job_full
);
    import plcr_pkg::*;

    logic en;

    logic                         r_v1, r_v2, r_v3, r_v4;
    logic signed [COORD_BITS-1:0] r_px1, r_py1, r_px2, r_py2, r_px3, r_py3;
    logic signed [DIFF_W-1:0]     r_dx, r_dy;
    logic                         r_in1, r_in2;
    logic signed [V_W-1:0]        r_val;
    logic [D_W+COORD_BITS-1:0]    r_t1x, r_t1y;
    logic [V_W+DIFF_W-3:0]        r_t2x, r_t2y;
    logic                         r_s1x, r_s1y, r_s2x, r_s2y;
    logic                         r_degen3;
    t_side                        r_side3;
    logic                         r_onseg3;
    t_job                         r_job;

    logic [COORD_BITS-1:0]   n_mpx, n_mpy;
    logic [V_W-2:0]          n_mv;
    logic [DIFF_W-2:0]       n_ma, n_mb;
    logic signed [NUM_W-1:0] n_e1x, n_e1y, n_e2x, n_e2y;

    assign en          = !(r_v4 && i_job_full);
    assign o_stall     = !en;
    assign o_job_valid = r_v4;
    assign o_job       = r_job;

    always_comb begin
        n_mpx = r_px2[COORD_BITS-1] ? COORD_BITS'(-r_px2) : COORD_BITS'(r_px2);
        n_mpy = r_py2[COORD_BITS-1] ? COORD_BITS'(-r_py2) : COORD_BITS'(r_py2);
        n_mv  = r_val[V_W-1] ? (V_W-1)'(-r_val) : (V_W-1)'(r_val);
        n_ma  = i_line.a[DIFF_W-1] ? (DIFF_W-1)'(-i_line.a) : (DIFF_W-1)'(i_line.a);
        n_mb  = i_line.b[DIFF_W-1] ? (DIFF_W-1)'(-i_line.b) : (DIFF_W-1)'(i_line.b);
        n_e1x = $signed(NUM_W'(r_t1x) << FRAC_BITS);
        n_e1y = $signed(NUM_W'(r_t1y) << FRAC_BITS);
        n_e2x = $signed(NUM_W'(r_t2x) << (FRAC_BITS + 1));
        n_e2y = $signed(NUM_W'(r_t2y) << (FRAC_BITS + 1));
        if (r_s1x) n_e1x = -n_e1x;
        if (r_s1y) n_e1y = -n_e1y;
        if (r_s2x) n_e2x = -n_e2x;
        if (r_s2y) n_e2y = -n_e2y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_px1 <= i_pt_x;
            r_py1 <= i_pt_y;
            r_dx  <= DIFF_W'(i_pt_x) - DIFF_W'(i_line.x1);
            r_dy  <= DIFF_W'(i_pt_y) - DIFF_W'(i_line.y1);
            r_in1 <= (i_pt_x >= i_line.lox) && (i_pt_x <= i_line.hix) &&
                     (i_pt_y >= i_line.loy) && (i_pt_y <= i_line.hiy);

            r_px2 <= r_px1;
            r_py2 <= r_py1;
            r_in2 <= r_in1;
            r_val <= V_W'(i_line.a) * V_W'(r_dx) + V_W'(i_line.b) * V_W'(r_dy);

            r_px3    <= r_px2;
            r_py3    <= r_py2;
            r_t1x    <= (D_W+COORD_BITS)'(i_line.d) * (D_W+COORD_BITS)'(n_mpx);
            r_t1y    <= (D_W+COORD_BITS)'(i_line.d) * (D_W+COORD_BITS)'(n_mpy);
            r_t2x    <= (V_W+DIFF_W-2)'(n_mv) * (V_W+DIFF_W-2)'(n_ma);
            r_t2y    <= (V_W+DIFF_W-2)'(n_mv) * (V_W+DIFF_W-2)'(n_mb);
            r_s1x    <= r_px2[COORD_BITS-1];
            r_s1y    <= r_py2[COORD_BITS-1];
            r_s2x    <= r_val[V_W-1] ^ i_line.a[DIFF_W-1];
            r_s2y    <= r_val[V_W-1] ^ i_line.b[DIFF_W-1];
            r_degen3 <= (i_line.d == '0);
            r_onseg3 <= (r_val == '0) && r_in2;
            if (r_val == '0) begin
                r_side3 <= SIDE_ON;
            end else if (r_val[V_W-1]) begin
                r_side3 <= SIDE_LEFT;
            end else begin
                r_side3 <= SIDE_RIGHT;
            end

            r_job.side   <= r_side3;
            r_job.on_seg <= r_onseg3;
            r_job.degen  <= r_degen3;
            if (r_degen3) begin
                r_job.num_x <= NUM_W'(r_px3) <<< FRAC_BITS;
                r_job.num_y <= NUM_W'(r_py3) <<< FRAC_BITS;
            end else begin
                r_job.num_x <= n_e1x - n_e2x;
                r_job.num_y <= n_e1y - n_e2y;
            end
        end
    end

endmodule

### hdl/plcr_queue.sv
// Short first-in first-out queue of jobs between the front and back pipelines.
// Depends on plcr_pkg.
module plcr_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  plcr_pkg::t_job i_wr_data,
    input  logic           i_rd,
    output plcr_pkg::t_job o_rd_data,
    output logic           o_full,
    output logic           o_empty
);
    import plcr_pkg::*;

    t_job            r_mem [QDEPTH];
    logic [QA_W:0]   r_wr_ptr, r_rd_ptr;

    assign o_empty   = (r_wr_ptr == r_rd_ptr);
    assign o_full    = (r_wr_ptr[QA_W-1:0] == r_rd_ptr[QA_W-1:0]) &&
                       (r_wr_ptr[QA_W] != r_rd_ptr[QA_W]);
    assign o_rd_data = r_mem[r_rd_ptr[QA_W-1:0]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            if (i_wr && !o_full) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (i_rd && !o_empty) r_rd_ptr <= r_rd_ptr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr && !o_full) r_mem[r_wr_ptr[QA_W-1:0]] <= i_wr_data;
    end

endmodule

### hdl/plcr_back.sv
// Back pipeline: one restoring-division bit per stage for both coordinates, then
// rounding, saturation and the output register. Depends on plcr_pkg.
module plcr_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  plcr_pkg::t_line i_line,
    input  logic            i_q_empty,
    input  plcr_pkg::t_job  i_job,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_stall,
    output logic [1:0]      o_side,
    output logic            o_on_segment,
    output logic            o_degenerate,
    output logic signed [plcr_pkg::RES_W-1:0] o_refl_x,
    output logic signed [plcr_pkg::RES_W-1:0] o_refl_y
);
    import plcr_pkg::*;

    logic           en;
    logic [D_W-1:0] div;

    logic           r_sv    [Q_W+1];
    logic [R_W-1:0] r_remx  [Q_W+1];
    logic [R_W-1:0] r_remy  [Q_W+1];
    logic [Q_W-1:0] r_lowx  [Q_W+1];
    logic [Q_W-1:0] r_lowy  [Q_W+1];
    logic [Q_W-1:0] r_qx    [Q_W+1];
    logic [Q_W-1:0] r_qy    [Q_W+1];
    logic           r_negx  [Q_W+1];
    logic           r_negy  [Q_W+1];
    t_side          r_side  [Q_W+1];
    logic           r_onseg [Q_W+1];
    logic           r_degen [Q_W+1];

    logic                    r_ov;
    t_side                   r_oside;
    logic                    r_oonseg, r_odegen;
    logic signed [RES_W-1:0] r_ox, r_oy;

    logic [MAG_W-1:0] n_magx, n_magy;
    logic [Q_W:0]     n_qrx, n_qry, n_limx, n_limy, n_qcx, n_qcy;

    assign en    = !(r_ov && i_stall);
    assign o_pop = en && !i_q_empty;
    assign div   = (i_line.d == '0) ? D_W'(1) : i_line.d;

    always_comb begin
        n_magx = i_job.num_x[NUM_W-1] ? MAG_W'(-i_job.num_x) : MAG_W'(i_job.num_x);
        n_magy = i_job.num_y[NUM_W-1] ? MAG_W'(-i_job.num_y) : MAG_W'(i_job.num_y);
        n_qrx  = (Q_W+1)'(r_qx[Q_W]) +
                 (Q_W+1)'({r_remx[Q_W], 1'b0} >= (R_W+1)'(div));
        n_qry  = (Q_W+1)'(r_qy[Q_W]) +
                 (Q_W+1)'({r_remy[Q_W], 1'b0} >= (R_W+1)'(div));
        n_limx = r_negx[Q_W] ? MAXPOS + 1'b1 : MAXPOS;
        n_limy = r_negy[Q_W] ? MAXPOS + 1'b1 : MAXPOS;
        n_qcx  = (n_qrx > n_limx) ? n_limx : n_qrx;
        n_qcy  = (n_qry > n_limy) ? n_limy : n_qry;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= Q_W; k++) r_sv[k] <= 1'b0;
            r_ov <= 1'b0;
        end else if (en) begin
            r_sv[0] <= !i_q_empty;
            for (int k = 1; k <= Q_W; k++) r_sv[k] <= r_sv[k-1];
            r_ov <= r_sv[Q_W];
        end
    end

    always_ff @(posedge i_clk) begin
        logic [R_W:0] cx, cy;
        if (en) begin
            r_remx[0]  <= R_W'(n_magx >> Q_W);
            r_remy[0]  <= R_W'(n_magy >> Q_W);
            r_lowx[0]  <= n_magx[Q_W-1:0];
            r_lowy[0]  <= n_magy[Q_W-1:0];
            r_qx[0]    <= '0;
            r_qy[0]    <= '0;
            r_negx[0]  <= i_job.num_x[NUM_W-1];
            r_negy[0]  <= i_job.num_y[NUM_W-1];
            r_side[0]  <= i_job.side;
            r_onseg[0] <= i_job.on_seg;
            r_degen[0] <= i_job.degen;
            for (int k = 1; k <= Q_W; k++) begin
                cx = {r_remx[k-1], r_lowx[k-1][Q_W-1]};
                cy = {r_remy[k-1], r_lowy[k-1][Q_W-1]};
                if (cx >= (R_W+1)'(div)) begin
                    r_remx[k] <= R_W'(cx - (R_W+1)'(div));
                    r_qx[k]   <= {r_qx[k-1][Q_W-2:0], 1'b1};
                end else begin
                    r_remx[k] <= R_W'(cx);
                    r_qx[k]   <= {r_qx[k-1][Q_W-2:0], 1'b0};
                end
                if (cy >= (R_W+1)'(div)) begin
                    r_remy[k] <= R_W'(cy - (R_W+1)'(div));
                    r_qy[k]   <= {r_qy[k-1][Q_W-2:0], 1'b1};
                end else begin
                    r_remy[k] <= R_W'(cy);
                    r_qy[k]   <= {r_qy[k-1][Q_W-2:0], 1'b0};
                end
                r_lowx[k]  <= r_lowx[k-1] << 1;
                r_lowy[k]  <= r_lowy[k-1] << 1;
                r_negx[k]  <= r_negx[k-1];
                r_negy[k]  <= r_negy[k-1];
                r_side[k]  <= r_side[k-1];
                r_onseg[k] <= r_onseg[k-1];
                r_degen[k] <= r_degen[k-1];
            end
            r_oside  <= r_side[Q_W];
            r_oonseg <= r_onseg[Q_W];
            r_odegen <= r_degen[Q_W];
            r_ox     <= r_negx[Q_W] ? RES_W'(-n_qcx) : RES_W'(n_qcx);
            r_oy     <= r_negy[Q_W] ? RES_W'(-n_qcy) : RES_W'(n_qcy);
        end
    end

    assign o_valid      = r_ov;
    assign o_side       = r_oside;
    assign o_on_segment = r_oonseg;
    assign o_degenerate = r_odegen;
    assign o_refl_x     = r_ox;
    assign o_refl_y     = r_oy;

    a_onseg_on_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_oonseg |-> r_oside == SIDE_ON)
        else $error("on-segment word not classified as on the line");
    a_degen_on_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_odegen |-> r_oside == SIDE_ON)
        else $error("degenerate word not classified as on the line");
    a_no_valid_after_reset: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !r_ov)
        else $error("output valid straight after reset");
    a_pop_only_when_moving: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_sv[0])
        else $error("popped word did not enter the divider");

endmodule

### hdl/point_line_classify_reflect_unit.sv
// Top level of the point-to-line classify and reflect unit.
// Depends on plcr_pkg, plcr_front, plcr_queue and plcr_back.
//
// Takes one point per clock while o_stall is low and returns one result word per
// point, in order, through four front stages (difference, line value, products,
// numerators), a four-word queue, a load stage, one division stage per quotient bit
// and a rounding stage. Each side may stall independently; the queue absorbs the
// words in flight. Endpoint registers, written through the plain write port, take
// effect via the line register, so write them only while the unit is idle.
module point_line_classify_reflect_unit (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [1:0]                             i_cfg_idx,
    input  logic [plcr_pkg::COORD_BITS-1:0]        i_cfg_data,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic signed [plcr_pkg::COORD_BITS-1:0] i_pt_x,
    input  logic signed [plcr_pkg::COORD_BITS-1:0] i_pt_y,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic [1:0]                             o_side,
    output logic                                   o_on_segment,
    output logic                                   o_degenerate,
    output logic signed [plcr_pkg::RES_W-1:0]      o_refl_x,
    output logic signed [plcr_pkg::RES_W-1:0]      o_refl_y
);
    import plcr_pkg::*;

    logic signed [COORD_BITS-1:0] r_ax, r_ay, r_bx, r_by;
    t_line                        r_line;
    logic signed [DIFF_W-1:0]     n_a, n_b;

    logic job_valid, q_full, q_empty, pop;
    t_job job_in, job_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ax <= '0;
            r_ay <= '0;
            r_bx <= '0;
            r_by <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_END_A_X: r_ax <= i_cfg_data;
                CFG_END_A_Y: r_ay <= i_cfg_data;
                CFG_END_B_X: r_bx <= i_cfg_data;
                CFG_END_B_Y: r_by <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign n_a = DIFF_W'(r_ay) - DIFF_W'(r_by);
    assign n_b = DIFF_W'(r_bx) - DIFF_W'(r_ax);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line <= '0;
        end else begin
            r_line.a   <= n_a;
            r_line.b   <= n_b;
            r_line.x1  <= r_ax;
            r_line.y1  <= r_ay;
            r_line.lox <= (r_ax < r_bx) ? r_ax : r_bx;
            r_line.hix <= (r_ax < r_bx) ? r_bx : r_ax;
            r_line.loy <= (r_ay < r_by) ? r_ay : r_by;
            r_line.hiy <= (r_ay < r_by) ? r_by : r_ay;
            r_line.d   <= D_W'(n_a) * D_W'(n_a) + D_W'(n_b) * D_W'(n_b);
        end
    end

    plcr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_pt_x      (i_pt_x),
        .i_pt_y      (i_pt_y),
        .i_line      (r_line),
        .o_job_valid (job_valid),
        .o_job       (job_in),
        .i_job_full  (q_full)
    );

    plcr_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (job_valid),
        .i_wr_data (job_in),
        .i_rd      (pop),
        .o_rd_data (job_out),
        .o_full    (q_full),
        .o_empty   (q_empty)
    );

    plcr_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_line       (r_line),
        .i_q_empty    (q_empty),
        .i_job        (job_out),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_side       (o_side),
        .o_on_segment (o_on_segment),
        .o_degenerate (o_degenerate),
        .o_refl_x     (o_refl_x),
        .o_refl_y     (o_refl_y)
    );

endmodule

### test/tb_point_line_classify_reflect_unit.sv
// Self-checking testbench for point_line_classify_reflect_unit: configures line endpoints,
// streams points with random gaps and stalls, and checks each result word against a predictor.
// Depends on plcr_pkg and the unit under test.
module tb_point_line_classify_reflect_unit;
    import plcr_pkg::*;

    localparam int LIMIT = 5000;
    localparam int DRAIN = 60;

    typedef struct {
        logic [1:0]              side;
        logic                    on_seg;
        logic                    degen;
        logic signed [RES_W-1:0] rx;
        logic signed [RES_W-1:0] ry;
    } t_expect;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [1:0]                     i_cfg_idx;
    logic [COORD_BITS-1:0]          i_cfg_data;
    logic                           i_valid;
    logic                           o_stall;
    logic signed [COORD_BITS-1:0]   i_pt_x;
    logic signed [COORD_BITS-1:0]   i_pt_y;
    logic                           o_valid;
    logic                           i_stall;
    logic [1:0]                     o_side;
    logic                           o_on_segment;
    logic                           o_degenerate;
    logic signed [RES_W-1:0]        o_refl_x;
    logic signed [RES_W-1:0]        o_refl_y;

    t_expect pending[$];
    int      n_errors = 0;
    int      quiet_cnt = 0;
    int      stall_mode = 0;
    int      gapless = 0;
    longint  lx1, ly1, lx2, ly2;

    point_line_classify_reflect_unit dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic signed [RES_W-1:0] reflect_q8(longint p, longint n, longint v,
                                                          longint d);
        longint maxp, num, mag, q, rem;
        maxp = (longint'(1) <<< (RES_W - 1)) - 1;
        num  = p * d * (longint'(1) <<< FRAC_BITS) - (longint'(1) <<< (FRAC_BITS + 1)) * v * n;
        mag  = num < 0 ? -num : num;
        q    = mag / d;
        rem  = mag % d;
        if (rem >= d - rem) q = q + 1;
        if (num >= 0) return RES_W'(q > maxp ? maxp : q);
        return RES_W'(-(q > maxp + 1 ? maxp + 1 : q));
    endfunction

    function automatic t_expect classify_point(longint px, longint py);
        t_expect e;
        longint  a, b, v, d;
        bit      inbox;
        a = ly1 - ly2;
        b = lx2 - lx1;
        v = a * (px - lx1) + b * (py - ly1);
        d = a * a + b * b;
        inbox = px >= (lx1 < lx2 ? lx1 : lx2) && px <= (lx1 < lx2 ? lx2 : lx1) &&
                py >= (ly1 < ly2 ? ly1 : ly2) && py <= (ly1 < ly2 ? ly2 : ly1);
        e.side   = v == 0 ? SIDE_ON : (v < 0 ? SIDE_LEFT : SIDE_RIGHT);
        e.on_seg = v == 0 && inbox;
        e.degen  = d == 0;
        if (d == 0) begin
            e.rx = RES_W'(px * (longint'(1) <<< FRAC_BITS));
            e.ry = RES_W'(py * (longint'(1) <<< FRAC_BITS));
        end else begin
            e.rx = reflect_q8(px, a, v, d);
            e.ry = reflect_q8(py, b, v, d);
        end
        return e;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (gapless > 0 || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic longint gcd(longint a, longint b);
        longint t;
        if (a < 0) a = -a;
        if (b < 0) b = -b;
        while (b != 0) begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic send_point(longint px, longint py);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_pt_x  <= COORD_BITS'(px);
        i_pt_y  <= COORD_BITS'(py);
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending.push_back(classify_point(px, py));
        if (gapless > 0) gapless--;
    endtask

    task automatic write_reg(t_cfg_idx idx, longint val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= COORD_BITS'(val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            CFG_END_A_X: lx1 = val;
            CFG_END_A_Y: ly1 = val;
            CFG_END_B_X: lx2 = val;
            default:     ly2 = val;
        endcase
    endtask

    task automatic set_line(longint x1, longint y1, longint x2, longint y2);
        wait_drained();
        write_reg(CFG_END_A_X, x1);
        write_reg(CFG_END_A_Y, y1);
        write_reg(CFG_END_B_X, x2);
        write_reg(CFG_END_B_Y, y2);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic send_on_line();
        longint g, k, px, py;
        g = gcd(lx2 - lx1, ly2 - ly1);
        if (g == 0) begin
            send_point(lx1, ly1);
            return;
        end
        k  = longint'($urandom_range(0, 3 * g)) - g;
        px = lx1 + k * ((lx2 - lx1) / g);
        py = ly1 + k * ((ly2 - ly1) / g);
        if (px < -2048 || px > 2047 || py < -2048 || py > 2047) send_point(lx2, ly2);
        else send_point(px, py);
    endtask

    task automatic test_reset_line();
        send_point(0, 0);
        send_point(5, -3);
        send_point(-2048, 2047);
        send_point(2047, -2048);
    endtask

    task automatic test_directed();
        set_line(-2048, -2048, 2047, 2047);
        send_point(0, 0);
        send_point(-2048, -2048);
        send_point(2047, 2047);
        send_point(-2048, 2047);
        send_point(2047, -2048);
        send_point(100, 101);
        set_line(2047, 2047, 2047, 2047);
        send_point(2047, 2047);
        send_point(-1, -1);
        set_line(-2048, 0, 2047, 0);
        send_point(-2048, 0);
        send_point(3000 - 3000, 2047);
        send_point(2047, -2048);
        set_line(0, -2048, 0, 2047);
        send_point(0, 2047);
        send_point(-2048, -2048);
        set_line(-2048, 2047, 2047, -2048);
        send_point(2047, 2047);
        send_point(-2048, -2048);
        send_point(1, 2);
    endtask

    task automatic test_random();
        longint c[4];
        for (int ph = 0; ph < 10; ph++) begin
            for (int j = 0; j < 4; j++) begin
                case ($urandom_range(0, 3))
                    0:       c[j] = $urandom_range(0, 1) ? 2047 : -2048;
                    1:       c[j] = longint'($urandom_range(0, 40)) - 20;
                    default: c[j] = longint'($urandom_range(0, 4095)) - 2048;
                endcase
            end
            if (ph == 3) begin
                c[2] = c[0];
                c[3] = c[1];
            end
            set_line(c[0], c[1], c[2], c[3]);
            for (int i = 0; i < 50; i++) begin
                if ($urandom_range(0, 59) == 0) gapless = $urandom_range(10, 30);
                if ($urandom_range(0, 99) == 0) begin
                    i_valid <= 1'b0;
                    while (pending.size() != 0) @(posedge i_clk);
                end
                case ($urandom_range(0, 9))
                    0, 1, 2: send_on_line();
                    3:       send_point($urandom_range(0, 1) ? 2047 : -2048,
                                        $urandom_range(0, 1) ? 2047 : -2048);
                    default: send_point(longint'($urandom_range(0, 4095)) - 2048,
                                        longint'($urandom_range(0, 4095)) - 2048);
                endcase
            end
        end
    endtask

    always @(posedge i_clk) begin
        if ($urandom_range(0, 49) == 0) stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0:       i_stall <= 1'b0;
            1:       i_stall <= $urandom_range(0, 3) == 0;
            default: i_stall <= $urandom_range(0, 19) != 0;
        endcase
    end

    always @(posedge i_clk) begin
        t_expect e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending.size() == 0) begin
                $error("result word with no point outstanding");
                n_errors++;
            end else begin
                e = pending.pop_front();
                if (o_side !== e.side) begin
                    $error("side expected %0d actual %0d", e.side, o_side);
                    n_errors++;
                end
                if (o_on_segment !== e.on_seg) begin
                    $error("on_segment expected %0d actual %0d", e.on_seg, o_on_segment);
                    n_errors++;
                end
                if (o_degenerate !== e.degen) begin
                    $error("degenerate expected %0d actual %0d", e.degen, o_degenerate);
                    n_errors++;
                end
                if (o_refl_x !== e.rx) begin
                    $error("refl_x expected %0d actual %0d", e.rx, o_refl_x);
                    n_errors++;
                end
                if (o_refl_y !== e.ry) begin
                    $error("refl_y expected %0d actual %0d", e.ry, o_refl_y);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_we) begin
            quiet_cnt <= 0;
        end else if (quiet_cnt >= LIMIT) begin
            $display("tb_point_line_classify_reflect_unit: errors");
            $finish;
        end else begin
            quiet_cnt <= quiet_cnt + 1;
        end
    end

    initial begin
        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= CFG_END_A_X;
        i_cfg_data <= '0;
        i_valid    <= 1'b0;
        i_pt_x     <= '0;
        i_pt_y     <= '0;
        i_stall    <= 1'b0;
        lx1 = 0;
        ly1 = 0;
        lx2 = 0;
        ly2 = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (4) @(posedge i_clk);
        test_reset_line();
        test_directed();
        test_random();
        wait_drained();
        if (n_errors == 0) begin
            $display("tb_point_line_classify_reflect_unit: clean");
        end else begin
            $display("tb_point_line_classify_reflect_unit: errors");
        end
        $finish;
    end

endmodule

### files.f
hdl/plcr_pkg.sv
hdl/plcr_front.sv
hdl/plcr_queue.sv
hdl/plcr_back.sv
hdl/point_line_classify_reflect_unit.sv
test/tb_point_line_classify_reflect_unit.sv
